// File: rtl/slsp_pkg.sv
// Package for the slew-limited 2D position stepper.
// Holds payload structs, action codes, state enum and reset constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slsp_pkg;

    localparam logic [31:0] MAX_SPEED_RESET = 32'd65536;
    localparam int          ARRIVE_EPS      = 66;
    localparam int          USEC_PER_SEC    = 1000000;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_GOAL  = 2'd1,
        ACT_PLACE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [19:0]        tick_usec;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               is_moving;
        logic               arrived;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LDIV,
        ST_SQR,
        ST_SQRT,
        ST_CMP,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_UPD,
        ST_ARR,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// File: rtl/slew_limited_2d_position_stepper_unit.sv
// Top level of the slew-limited 2D position stepper.
// Bit-serial multiply, divide and square root on one shared shift datapath.
// Depends on slsp_pkg.
//
//  channel | direction | handshake         | payload
//  in      | input     | i_valid/o_stall   | slsp_pkg::t_in_item
//  out     | output    | o_valid/i_stall   | slsp_pkg::t_out_item
//  cfg     | input     | i_cfg_we/i_cfg_wd | max_speed, 32 bits
//
// A tick while moving runs MUL, LDIV, SQR, SQRT, CMP, MULX, DIVX, MULY, DIVY,
// UPD, ARR and OUT, or skips from CMP to ARR when it snaps onto the target. Each
// serial operation retires one step per cycle: multiplies 20 or 32, divides 64,
// squares 32, square root 32. One item is worked on at a time; the result sits
// in an output register and the next item is taken once it transfers.
// Reset is synchronous, active low, clears the state and loads max_speed with 1.0.
`timescale 1ns / 1ps
`default_nettype none
module slew_limited_2d_position_stepper_unit #(
    parameter int ARRIVE_EPS = slsp_pkg::ARRIVE_EPS
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire slsp_pkg::t_in_item   i_data,
    output logic                      o_valid,
    input  wire                       i_stall,
    output slsp_pkg::t_out_item       o_data,
    input  wire                       i_cfg_we,
    input  wire [31:0]                i_cfg_wd
);

    slsp_pkg::t_state r_state, n_state;

    logic [31:0]        r_speed;
    logic signed [31:0] r_px, r_py, r_gx, r_gy;
    logic               r_mov;

    logic [63:0]  r_a, r_b, r_acc, r_rem;
    logic [6:0]   r_cnt;
    logic [32:0]  r_ax, r_ay;
    logic         r_s, r_nx, r_ny;
    logic [63:0]  r_lim;
    logic [31:0]  r_dist;
    logic [63:0]  r_mx;
    logic         r_arr;

    logic [32:0] dx, dy;
    assign dx = {r_gx[31], r_gx} - {r_px[31], r_px};
    assign dy = {r_gy[31], r_gy} - {r_py[31], r_py};

    logic [64:0] trial;
    logic [63:0] rem_sh;
    assign rem_sh = {r_rem[62:0], r_a[63]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_b};

    logic [65:0] sq_rem;
    logic [65:0] sq_try;
    assign sq_rem = {r_rem, r_a[63:62]};
    assign sq_try = sq_rem - {32'd0, r_acc[31:0], 2'b01};

    logic [32:0] ex, ey;

    always_comb begin
        ex = {r_px[31], r_px} - {r_gx[31], r_gx};
        ey = {r_py[31], r_py} - {r_gy[31], r_gy};
        if (ex[32]) ex = -ex;
        if (ey[32]) ey = -ey;
    end

    assign o_stall = (r_state != slsp_pkg::ST_IDLE) || o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slsp_pkg::ST_IDLE;
            r_speed <= slsp_pkg::MAX_SPEED_RESET;
            r_px <= '0; r_py <= '0; r_gx <= '0; r_gy <= '0;
            r_mov <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_speed <= i_cfg_wd;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                slsp_pkg::ST_IDLE: begin
                    r_arr <= 1'b0;
                    if (i_valid && !o_stall) begin
                        unique case (slsp_pkg::t_action'(i_data.action))
                            slsp_pkg::ACT_GOAL: begin
                                r_gx <= i_data.coord_x; r_gy <= i_data.coord_y;
                                r_mov <= 1'b1;
                            end
                            slsp_pkg::ACT_PLACE: begin
                                r_px <= i_data.coord_x; r_py <= i_data.coord_y;
                            end
                            default: ;
                        endcase
                        r_a   <= {32'd0, r_speed};
                        r_b   <= {44'd0, i_data.tick_usec};
                        r_acc <= '0;
                        r_cnt <= 7'd0;
                    end
                end
                slsp_pkg::ST_MUL: begin
                    if (r_b[0]) r_acc <= r_acc + r_a;
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                    r_cnt <= (r_cnt == 7'd19) ? 7'd0 : r_cnt + 7'd1;
                end
                slsp_pkg::ST_LDIV: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= r_acc; r_rem <= '0;
                        r_b <= 64'(slsp_pkg::USEC_PER_SEC);
                        r_acc <= '0; r_cnt <= 7'd1;
                    end else begin
                        r_a <= r_a << 1;
                        if (!trial[64]) begin
                            r_rem <= trial[63:0]; r_acc <= {r_acc[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh; r_acc <= {r_acc[62:0], 1'b0};
                        end
                        r_cnt <= (r_cnt == 7'd64) ? 7'd0 : r_cnt + 7'd1;
                    end
                end
                slsp_pkg::ST_SQR: begin
                    if (r_cnt == 7'd0) begin
                        r_nx <= dx[32]; r_ny <= dy[32];
                        r_ax <= dx[32] ? -dx : dx;
                        r_ay <= dy[32] ? -dy : dy;
                        r_lim <= r_acc;
                        r_cnt <= 7'd1;
                    end else if (r_cnt == 7'd1) begin
                        r_s <= r_ax[32] | r_ax[31] | r_ay[32] | r_ay[31];
                        r_cnt <= 7'd2;
                    end else if (r_cnt == 7'd2) begin
                        if (r_s) begin
                            r_ax <= r_ax >> 1; r_ay <= r_ay >> 1; r_lim <= r_lim >> 1;
                        end
                        r_cnt <= 7'd3;
                    end else if (r_cnt == 7'd3) begin
                        r_a <= {32'd0, r_ax[31:0]}; r_b <= {32'd0, r_ax[31:0]};
                        r_acc <= '0; r_rem <= '0; r_cnt <= 7'd4;
                    end else if (r_cnt < 7'd36) begin
                        if (r_b[0]) r_acc <= r_acc + r_a;
                        if (r_cnt == 7'd35) begin
                            r_a <= {32'd0, r_ay[31:0]}; r_b <= {32'd0, r_ay[31:0]};
                        end else begin
                            r_a <= r_a << 1; r_b <= r_b >> 1;
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end else if (r_cnt == 7'd36) begin
                        r_rem <= r_acc; r_acc <= '0; r_cnt <= 7'd37;
                    end else begin
                        if (r_b[0]) r_acc <= r_acc + r_a;
                        r_a <= r_a << 1; r_b <= r_b >> 1;
                        r_cnt <= (r_cnt == 7'd68) ? 7'd0 : r_cnt + 7'd1;
                    end
                end
                slsp_pkg::ST_SQRT: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= r_acc + r_rem; r_rem <= '0; r_acc <= '0;
                        r_cnt <= 7'd1;
                    end else begin
                        r_a <= r_a << 2;
                        if (!sq_try[65] && sq_rem >= {32'd0, r_acc[31:0], 2'b01}) begin
                            r_rem <= sq_try[63:0]; r_acc <= {r_acc[62:0], 1'b1};
                        end else begin
                            r_rem <= sq_rem[63:0]; r_acc <= {r_acc[62:0], 1'b0};
                        end
                        r_cnt <= (r_cnt == 7'd32) ? 7'd0 : r_cnt + 7'd1;
                    end
                end
                slsp_pkg::ST_CMP: begin
                    r_dist <= r_acc[31:0];
                end
                slsp_pkg::ST_MULX, slsp_pkg::ST_MULY: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= r_lim;
                        r_b <= {31'd0, (r_state == slsp_pkg::ST_MULX) ? r_ax : r_ay};
                        r_acc <= '0; r_cnt <= 7'd1;
                    end else begin
                        if (r_b[0]) r_acc <= r_acc + r_a;
                        r_a <= r_a << 1; r_b <= r_b >> 1;
                        r_cnt <= (r_cnt == 7'd32) ? 7'd0 : r_cnt + 7'd1;
                    end
                end
                slsp_pkg::ST_DIVX, slsp_pkg::ST_DIVY: begin
                    if (r_cnt == 7'd0) begin
                        r_a <= r_acc; r_rem <= '0; r_b <= {32'd0, r_dist};
                        r_acc <= '0; r_cnt <= 7'd1;
                    end else begin
                        r_a <= r_a << 1;
                        if (!trial[64]) begin
                            r_rem <= trial[63:0]; r_acc <= {r_acc[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh; r_acc <= {r_acc[62:0], 1'b0};
                        end
                        r_cnt <= (r_cnt == 7'd64) ? 7'd0 : r_cnt + 7'd1;
                    end
                    if (r_state == slsp_pkg::ST_DIVX && r_cnt == 7'd64)
                        r_mx <= r_s ? {r_acc[61:0], ~trial[64], 1'b0}
                                    : {r_acc[62:0], ~trial[64]};
                end
                slsp_pkg::ST_UPD: begin
                    r_px <= r_nx ? r_px - r_mx[31:0] : r_px + r_mx[31:0];
                    r_py <= r_ny ? r_py - (r_s ? {r_acc[30:0], 1'b0} : r_acc[31:0])
                                 : r_py + (r_s ? {r_acc[30:0], 1'b0} : r_acc[31:0]);
                end
                slsp_pkg::ST_ARR: begin
                    if (ex < 33'(ARRIVE_EPS) && ey < 33'(ARRIVE_EPS)) begin
                        r_mov <= 1'b0; r_arr <= 1'b1;
                    end
                end
                slsp_pkg::ST_OUT: begin
                    o_valid <= 1'b1;
                    o_data.pos_x <= r_px;
                    o_data.pos_y <= r_py;
                    o_data.is_moving <= r_mov;
                    o_data.arrived <= r_arr;
                end
                default: ;
            endcase
            if (r_state == slsp_pkg::ST_CMP && !({32'd0, r_acc[31:0]} > r_lim)) begin
                r_px <= r_gx; r_py <= r_gy;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slsp_pkg::ST_IDLE:
                if (i_valid && !o_stall)
                    n_state = (i_data.action == slsp_pkg::ACT_TICK && r_mov)
                              ? slsp_pkg::ST_MUL : slsp_pkg::ST_OUT;
            slsp_pkg::ST_MUL:  if (r_cnt == 7'd19) n_state = slsp_pkg::ST_LDIV;
            slsp_pkg::ST_LDIV: if (r_cnt == 7'd64) n_state = slsp_pkg::ST_SQR;
            slsp_pkg::ST_SQR:  if (r_cnt == 7'd68) n_state = slsp_pkg::ST_SQRT;
            slsp_pkg::ST_SQRT: if (r_cnt == 7'd32) n_state = slsp_pkg::ST_CMP;
            slsp_pkg::ST_CMP:
                n_state = ({32'd0, r_acc[31:0]} > r_lim) ? slsp_pkg::ST_MULX
                                                         : slsp_pkg::ST_ARR;
            slsp_pkg::ST_MULX: if (r_cnt == 7'd32) n_state = slsp_pkg::ST_DIVX;
            slsp_pkg::ST_DIVX: if (r_cnt == 7'd64) n_state = slsp_pkg::ST_MULY;
            slsp_pkg::ST_MULY: if (r_cnt == 7'd32) n_state = slsp_pkg::ST_DIVY;
            slsp_pkg::ST_DIVY: if (r_cnt == 7'd64) n_state = slsp_pkg::ST_UPD;
            slsp_pkg::ST_UPD:  n_state = slsp_pkg::ST_ARR;
            slsp_pkg::ST_ARR:  n_state = slsp_pkg::ST_OUT;
            slsp_pkg::ST_OUT:  n_state = slsp_pkg::ST_IDLE;
            default:           n_state = slsp_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/slsp_checker.sv
// Port-level checks for the slew-limited 2D position stepper.
// Bound onto the top level; depends on slsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slsp_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_valid,
    input wire                      o_stall,
    input wire slsp_pkg::t_in_item  i_data,
    input wire                      o_valid,
    input wire                      i_stall,
    input wire slsp_pkg::t_out_item o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_arr_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.arrived && o_data.is_moving))
        else $error("arrived while still moving");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken during work");

    a_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.action == slsp_pkg::ACT_GOAL
        |=> ##1 o_valid && o_data.is_moving)
        else $error("set target did not start moving");

endmodule

bind slew_limited_2d_position_stepper_unit slsp_checker u_slsp_checker (.*);
`default_nettype wire

// File: dv/slsp_scoreboard.sv
// Checker for the slew-limited 2D position stepper: predicts each result and compares.
// Watches the input, output and configuration ports of the block.
// Depends on slsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slsp_scoreboard (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire slsp_pkg::t_in_item   i_in_data,
    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire slsp_pkg::t_out_item  i_out_data,
    input  wire                       i_cfg_we,
    input  wire [31:0]                i_cfg_wd,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_arrivals
);

    logic [31:0]         speed;
    logic signed [31:0]  cur_x, cur_y, goal_x, goal_y;
    logic                moving;
    slsp_pkg::t_out_item expected_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned magnitude(input longint d);
        return (d < 0) ? longint'(-d) : longint'(d);
    endfunction

    function automatic bit tick_arrives(input logic [19:0] usec);
        longint unsigned lim, ax, ay, span, mx, my;
        longint dx, dy;
        int sh;
        if (!moving) return 1'b0;
        lim = (longint'({32'd0, speed}) * longint'(usec)) / slsp_pkg::USEC_PER_SEC;
        dx = longint'(goal_x) - longint'(cur_x);
        dy = longint'(goal_y) - longint'(cur_y);
        ax = magnitude(dx);
        ay = magnitude(dy);
        sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
        ax = ax >> sh;
        ay = ay >> sh;
        lim = lim >> sh;
        span = int_sqrt(ax * ax + ay * ay);
        if (span > lim) begin
            mx = ((ax * lim) / span) << sh;
            my = ((ay * lim) / span) << sh;
            cur_x = 32'(longint'(cur_x) + ((dx < 0) ? -longint'(mx) : longint'(mx)));
            cur_y = 32'(longint'(cur_y) + ((dy < 0) ? -longint'(my) : longint'(my)));
        end else begin
            cur_x = goal_x;
            cur_y = goal_y;
        end
        if (magnitude(longint'(cur_x) - longint'(goal_x)) < slsp_pkg::ARRIVE_EPS &&
            magnitude(longint'(cur_y) - longint'(goal_y)) < slsp_pkg::ARRIVE_EPS) begin
            moving = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic slsp_pkg::t_out_item step_position(input slsp_pkg::t_in_item it);
        slsp_pkg::t_out_item r;
        r.arrived = 1'b0;
        case (slsp_pkg::t_action'(it.action))
            slsp_pkg::ACT_TICK:  r.arrived = tick_arrives(it.tick_usec);
            slsp_pkg::ACT_GOAL: begin
                goal_x = it.coord_x;
                goal_y = it.coord_y;
                moving = 1'b1;
            end
            slsp_pkg::ACT_PLACE: begin
                cur_x = it.coord_x;
                cur_y = it.coord_y;
            end
            default: ;
        endcase
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        r.is_moving = moving;
        return r;
    endfunction

    always @(posedge i_clk) begin
        slsp_pkg::t_out_item exp_item;
        if (!i_rst_n) begin
            speed = slsp_pkg::MAX_SPEED_RESET;
            cur_x = 0;
            cur_y = 0;
            goal_x = 0;
            goal_y = 0;
            moving = 1'b0;
            expected_q.delete();
            o_errors = 0;
            o_arrivals = 0;
        end else begin
            if (i_cfg_we) speed = i_cfg_wd;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_errors++;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (i_out_data.pos_x !== exp_item.pos_x ||
                        i_out_data.pos_y !== exp_item.pos_y ||
                        i_out_data.is_moving !== exp_item.is_moving ||
                        i_out_data.arrived !== exp_item.arrived) begin
                        $display({"%0t: mismatch expected x=%h y=%h mv=%b arr=%b",
                                  " got x=%h y=%h mv=%b arr=%b"},
                            $time, exp_item.pos_x, exp_item.pos_y, exp_item.is_moving,
                            exp_item.arrived, i_out_data.pos_x, i_out_data.pos_y,
                            i_out_data.is_moving, i_out_data.arrived);
                        o_errors++;
                    end
                    if (exp_item.arrived) o_arrivals++;
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(step_position(i_in_data));
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

// File: dv/slew_limited_2d_position_stepper_unit_tb.sv
// Testbench top for the slew-limited 2D position stepper.
// Drives directed and random transfers with random stalls and speed settings.
// Depends on slsp_pkg, the block and slsp_scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module slew_limited_2d_position_stepper_unit_tb;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    slsp_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    slsp_pkg::t_out_item o_data;
    logic                i_cfg_we = 1'b0;
    logic [31:0]         i_cfg_wd = '0;
    int                  errors, pending, arrivals;
    int                  cycles = 0;
    int                  sent = 0;
    bit                  holdoff_req = 1'b0;

    always #6 i_clk = ~i_clk;

    slew_limited_2d_position_stepper_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wd(i_cfg_wd)
    );

    slsp_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wd(i_cfg_wd),
        .o_errors(errors), .o_pending(pending), .o_arrivals(arrivals)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls in runs; a requested hold-off lasts a long stretch.
    initial begin
        int run;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                i_stall <= 1'b1;
                repeat (1500) @(negedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            i_stall <= ($urandom_range(0, 2) == 0);
            repeat (run - 1) @(negedge i_clk);
        end
    end

    task automatic send(input logic [1:0] act, input logic [19:0] usec,
                        input logic [31:0] cx, input logic [31:0] cy);
        int gap;
        gap = $urandom_range(0, 9);
        gap = (gap < 6) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(20, 80);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{action: act, tick_usec: usec, coord_x: cx, coord_y: cy};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain_and_set(input logic [31:0] speed);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wd <= speed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] near_coord(input logic [31:0] base);
        return base + 32'($signed($urandom_range(0, 400000)) - 200000);
    endfunction

    task automatic random_journeys(input int count);
        logic [31:0] px, py;
        int pick;
        while (count > 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send(2'($urandom_range(0, 3)), 20'($urandom_range(0, 1000000)),
                     $urandom, $urandom);
                count--;
            end else begin
                px = (pick < 3) ? $urandom : near_coord(32'd0);
                py = (pick < 3) ? $urandom : near_coord(32'd0);
                send(slsp_pkg::ACT_PLACE, 20'($urandom), px, py);
                send(slsp_pkg::ACT_GOAL, 20'($urandom),
                     (pick == 1) ? $urandom : near_coord(px),
                     (pick == 2) ? $urandom : near_coord(py));
                count -= 2;
                repeat ($urandom_range(2, 8)) begin
                    send(slsp_pkg::ACT_TICK,
                         ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1000000))
                                                     : 20'($urandom_range(0, 50000)),
                         $urandom, $urandom);
                    count--;
                end
            end
        end
    endtask

    initial begin
        logic [31:0] speeds[5];
        speeds = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000, 32'h0000_8000};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_NONE, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(slsp_pkg::ACT_GOAL, 20'd0, 32'h0000_0010, 32'hFFFF_FFF0);
        send(slsp_pkg::ACT_TICK, 20'd0, '0, '0);
        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_PLACE, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(slsp_pkg::ACT_GOAL, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_TICK, 20'd1, '0, '0);
        send(slsp_pkg::ACT_TICK, 20'd0, '0, '0);
        drain_and_set(32'hFFFF_FFFF);
        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_PLACE, '0, 32'd1000, 32'd1000);
        send(slsp_pkg::ACT_GOAL, '0, 32'd1065, 32'd935);
        send(slsp_pkg::ACT_TICK, 20'd0, '0, '0);
        send(slsp_pkg::ACT_GOAL, '0, 32'd1066, 32'd1000);
        send(slsp_pkg::ACT_TICK, 20'd0, '0, '0);
        send(slsp_pkg::ACT_TICK, 20'd1000000, '0, '0);
        send(slsp_pkg::ACT_NONE, '0, '0, '0);

        foreach (speeds[k]) begin
            drain_and_set(speeds[k] ^ ((k == 4) ? $urandom_range(0, 65535) : 0));
            if (k == 2) holdoff_req = 1'b1;
            random_journeys(70);
        end
        drain_and_set($urandom);
        random_journeys(60);

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (500) @(negedge i_clk);
        $display("Sent %0d transfers across several speed settings; %0d ticks reached the goal.",
                 sent, arrivals);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
